// ===== sv/udrb_pkg.sv =====
// Shared constants, codes and types of the UART dual ring buffer.
package udrb_pkg;

  localparam int RING_DEPTH = 8;
  localparam int PTR_W      = $clog2(RING_DEPTH);
  localparam int FILL_W     = $clog2(RING_DEPTH + 1);
  localparam int BYTE_W     = 8;
  localparam int MODE_W     = 3;
  localparam int LEVEL_W    = 4;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 24;

  typedef enum logic [MODE_W-1:0] {
    MODE_TX_PUSH  = 3'd0,
    MODE_TX_TAKE  = 3'd1,
    MODE_RX_BYTE  = 3'd2,
    MODE_RX_POP   = 3'd3,
    MODE_RX_FLUSH = 3'd4,
    MODE_TX_FLUSH = 3'd5
  } mode_t;

  // Command to one ring for the current request.
  typedef struct packed {
    logic push;
    logic pop;
    logic flush;
  } ring_cmd_t;

  // Status of one ring, taken from its registers.
  typedef struct packed {
    logic [FILL_W-1:0] fill;
    logic [BYTE_W-1:0] rd_byte;
    logic              full;
    logic              empty;
  } ring_stat_t;

  // One result request.
  typedef struct packed {
    logic [LEVEL_W-1:0] rx_level;
    logic [LEVEL_W-1:0] tx_level;
    logic               tx_irq_on;
    logic               rx_overwrote;
    logic [BYTE_W-1:0]  out_byte;
    logic               accepted;
  } result_t;

endpackage

// ===== sv/udrb_ring.sv =====
// One byte ring: storage, read and write positions and fill count.
module udrb_ring (
  input  logic                          clk,
  input  logic                          rst_n,
  input  udrb_pkg::ring_cmd_t           cmd,
  input  logic [udrb_pkg::BYTE_W-1:0]   wr_byte,
  output udrb_pkg::ring_stat_t          stat,
  output logic [udrb_pkg::FILL_W-1:0]   fill_nxt
);

  logic [udrb_pkg::BYTE_W-1:0] store_r [udrb_pkg::RING_DEPTH];
  logic [udrb_pkg::PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [udrb_pkg::PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [udrb_pkg::FILL_W-1:0] fill_r;

  function automatic logic [udrb_pkg::PTR_W-1:0] next_pos(
    input logic [udrb_pkg::PTR_W-1:0] p
  );
    if (p == udrb_pkg::PTR_W'(udrb_pkg::RING_DEPTH - 1)) begin
      return '0;
    end
    return p + udrb_pkg::PTR_W'(1);
  endfunction

  always_comb begin
    rd_ptr_nxt = rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    fill_nxt   = fill_r;
    if (cmd.flush) begin
      rd_ptr_nxt = '0;
      wr_ptr_nxt = '0;
      fill_nxt   = '0;
    end else begin
      if (cmd.push) begin
        wr_ptr_nxt = next_pos(wr_ptr_r);
      end
      if (cmd.pop) begin
        rd_ptr_nxt = next_pos(rd_ptr_r);
      end
      // push and pop together (overwrite when full) leave the count alone
      if (cmd.push && !cmd.pop) begin
        fill_nxt = fill_r + udrb_pkg::FILL_W'(1);
      end else if (cmd.pop && !cmd.push) begin
        fill_nxt = fill_r - udrb_pkg::FILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push && !cmd.flush) begin
      store_r[wr_ptr_r] <= wr_byte;
    end
  end

  assign stat.fill    = fill_r;
  assign stat.rd_byte = store_r[rd_ptr_r];
  assign stat.full    = (fill_r == udrb_pkg::FILL_W'(udrb_pkg::RING_DEPTH));
  assign stat.empty   = (fill_r == '0);

endmodule

// ===== sv/udrb_exec.sv =====
// Operation decode: ring commands, interrupt enable update and result fields.
module udrb_exec (
  input  logic                          go,
  input  logic [udrb_pkg::MODE_W-1:0]   mode,
  input  udrb_pkg::ring_stat_t          tx_stat,
  input  udrb_pkg::ring_stat_t          rx_stat,
  input  logic [udrb_pkg::FILL_W-1:0]   tx_fill_nxt,
  input  logic [udrb_pkg::FILL_W-1:0]   rx_fill_nxt,
  input  logic                          irq_r,
  output udrb_pkg::ring_cmd_t           tx_cmd,
  output udrb_pkg::ring_cmd_t           rx_cmd,
  output logic                          irq_nxt,
  output udrb_pkg::result_t             res
);

  logic host_pop;

  always_comb begin
    tx_cmd   = '0;
    rx_cmd   = '0;
    host_pop = 1'b0;
    irq_nxt  = irq_r;
    res      = '0;
    if (go) begin
      case (mode)
        udrb_pkg::MODE_TX_PUSH: begin
          tx_cmd.push = !tx_stat.full;
          if (!tx_stat.full) begin
            irq_nxt = 1'b1;
          end
        end
        udrb_pkg::MODE_TX_TAKE: begin
          tx_cmd.pop = !tx_stat.empty;
          // enable drops once the ring is empty after the take
          if (tx_stat.empty || tx_stat.fill == udrb_pkg::FILL_W'(1)) begin
            irq_nxt = 1'b0;
          end
        end
        udrb_pkg::MODE_RX_BYTE: begin
          rx_cmd.push      = 1'b1;
          rx_cmd.pop       = rx_stat.full;
          res.rx_overwrote = rx_stat.full;
        end
        udrb_pkg::MODE_RX_POP: begin
          host_pop   = !rx_stat.empty;
          rx_cmd.pop = !rx_stat.empty;
        end
        udrb_pkg::MODE_RX_FLUSH: rx_cmd.flush = 1'b1;
        udrb_pkg::MODE_TX_FLUSH: tx_cmd.flush = 1'b1;
        default: ;
      endcase
      res.accepted = tx_cmd.push | tx_cmd.pop | host_pop;
      if (tx_cmd.pop) begin
        res.out_byte = tx_stat.rd_byte;
      end else if (host_pop) begin
        res.out_byte = rx_stat.rd_byte;
      end
    end
    res.tx_irq_on = irq_nxt;
    res.tx_level  = udrb_pkg::LEVEL_W'(tx_fill_nxt);
    res.rx_level  = udrb_pkg::LEVEL_W'(rx_fill_nxt);
  end

endmodule

// ===== sv/uart_dual_ring_buffer.sv =====
// Top level: request and result registers around the transmit and receive rings.
// Each request is one operation (host push, UART take, received byte, host pop,
// flush of either ring) and yields exactly one result. A request is latched in
// an input register, executed against the ring state once the result register
// is free or being taken, and written into it, so the block takes one request per
// clock unless the output stalls; ready only drops while the result register
// is full and not being taken. The transmit ring refuses pushes when full; the
// receive ring overwrites its oldest byte when full. Rings are 8 bytes deep.
module uart_dual_ring_buffer (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [2:0] mode, [10:3] data_byte, [15:11] zero
  input  logic [udrb_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [0] accepted, [8:1] out_byte, [9] rx_overwrote, [10] tx_irq_on,
  // [14:11] tx_level, [18:15] rx_level, [23:19] zero
  output logic [udrb_pkg::OUT_DATA_W-1:0]   out_tdata
);

  localparam int RES_W = $bits(udrb_pkg::result_t);

  logic                          in_vld_r;
  logic [udrb_pkg::MODE_W-1:0]   mode_r;
  logic [udrb_pkg::BYTE_W-1:0]   byte_r;
  logic                          out_vld_r;
  udrb_pkg::result_t             res_r;
  udrb_pkg::result_t             res_nxt;
  logic                          irq_r, irq_nxt;
  logic                          fire;

  udrb_pkg::ring_cmd_t           tx_cmd, rx_cmd;
  udrb_pkg::ring_stat_t          tx_stat, rx_stat;
  logic [udrb_pkg::FILL_W-1:0]   tx_fill_nxt, rx_fill_nxt;

  assign fire      = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || fire;

  udrb_exec u_exec (
    .go          (fire),
    .mode        (mode_r),
    .tx_stat     (tx_stat),
    .rx_stat     (rx_stat),
    .tx_fill_nxt (tx_fill_nxt),
    .rx_fill_nxt (rx_fill_nxt),
    .irq_r       (irq_r),
    .tx_cmd      (tx_cmd),
    .rx_cmd      (rx_cmd),
    .irq_nxt     (irq_nxt),
    .res         (res_nxt)
  );

  udrb_ring u_tx_ring (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (tx_cmd),
    .wr_byte  (byte_r),
    .stat     (tx_stat),
    .fill_nxt (tx_fill_nxt)
  );

  udrb_ring u_rx_ring (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (rx_cmd),
    .wr_byte  (byte_r),
    .stat     (rx_stat),
    .fill_nxt (rx_fill_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      irq_r     <= 1'b0;
    end else begin
      if (in_tready) begin
        in_vld_r <= in_tvalid;
      end
      if (fire) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
      irq_r <= irq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      mode_r <= in_tdata[udrb_pkg::MODE_W-1:0];
      byte_r <= in_tdata[udrb_pkg::MODE_W +: udrb_pkg::BYTE_W];
    end
    if (fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {(udrb_pkg::OUT_DATA_W - RES_W)'(0), res_r};

endmodule

// ===== dv/tb_uart_dual_ring_buffer.sv =====
// Testbench for the UART dual ring buffer: directed, random and backpressure tests.
module tb_uart_dual_ring_buffer;

  localparam logic [udrb_pkg::MODE_W-1:0] OP_UNUSED_6 = 3'd6;
  localparam logic [udrb_pkg::MODE_W-1:0] OP_UNUSED_7 = 3'd7;
  localparam int DRAIN_LIMIT   = 5000;
  localparam int TAIL_CYCLES   = 6;
  localparam int STALL_CYCLES  = 80;

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [udrb_pkg::IN_DATA_W-1:0]  in_tdata;
  logic                            out_tvalid;
  logic                            out_tready;
  logic [udrb_pkg::OUT_DATA_W-1:0] out_tdata;

  uart_dual_ring_buffer u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Shadow copy of both rings.
  logic [udrb_pkg::BYTE_W-1:0] tx_ring [udrb_pkg::RING_DEPTH];
  logic [udrb_pkg::BYTE_W-1:0] rx_ring [udrb_pkg::RING_DEPTH];
  logic [udrb_pkg::PTR_W-1:0]  tx_rd, tx_wr, rx_rd, rx_wr;
  logic [udrb_pkg::FILL_W-1:0] tx_cnt, rx_cnt;
  logic                        irq_en;

  udrb_pkg::result_t due_results [$];
  udrb_pkg::result_t seen, want;
  int      mismatch_count = 0;
  int      send_idle_pct  = 0;
  int      recv_idle_pct  = 0;
  int      stall_asks     = 0;
  int      stall_taken    = 0;
  int      stall_left     = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic report_mismatch(string what, int got, int exp);
    $display("[%0t] MISMATCH %s: got 0x%0h expected 0x%0h", $realtime, what, got, exp);
    mismatch_count++;
  endtask

  function automatic logic [udrb_pkg::PTR_W-1:0] wrap_inc(logic [udrb_pkg::PTR_W-1:0] p);
    return (p == udrb_pkg::PTR_W'(udrb_pkg::RING_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  task automatic ring_model_reset();
    for (int i = 0; i < udrb_pkg::RING_DEPTH; i++) begin
      tx_ring[i] = '0;
      rx_ring[i] = '0;
    end
    tx_rd = '0; tx_wr = '0; tx_cnt = '0;
    rx_rd = '0; rx_wr = '0; rx_cnt = '0;
    irq_en = 1'b0;
  endtask

  // Applies one operation to the shadow rings and returns the status it yields.
  function automatic udrb_pkg::result_t apply_ring_op(logic [udrb_pkg::MODE_W-1:0] op,
                                                      logic [udrb_pkg::BYTE_W-1:0] b);
    udrb_pkg::result_t r;
    r = '0;
    case (op)
      udrb_pkg::MODE_TX_PUSH: begin
        if (tx_cnt < udrb_pkg::FILL_W'(udrb_pkg::RING_DEPTH)) begin
          tx_ring[tx_wr] = b;
          tx_wr = wrap_inc(tx_wr);
          tx_cnt = tx_cnt + 1'b1;
          irq_en = 1'b1;
          r.accepted = 1'b1;
        end
      end
      udrb_pkg::MODE_TX_TAKE: begin
        if (tx_cnt != 0) begin
          r.out_byte = tx_ring[tx_rd];
          tx_rd = wrap_inc(tx_rd);
          tx_cnt = tx_cnt - 1'b1;
          r.accepted = 1'b1;
        end
        if (tx_cnt == 0) irq_en = 1'b0;
      end
      udrb_pkg::MODE_RX_BYTE: begin
        rx_ring[rx_wr] = b;
        rx_wr = wrap_inc(rx_wr);
        if (rx_cnt < udrb_pkg::FILL_W'(udrb_pkg::RING_DEPTH)) begin
          rx_cnt = rx_cnt + 1'b1;
        end else begin
          // full: oldest unread byte is lost
          rx_rd = wrap_inc(rx_rd);
          r.rx_overwrote = 1'b1;
        end
      end
      udrb_pkg::MODE_RX_POP: begin
        if (rx_cnt != 0) begin
          r.out_byte = rx_ring[rx_rd];
          rx_rd = wrap_inc(rx_rd);
          rx_cnt = rx_cnt - 1'b1;
          r.accepted = 1'b1;
        end
      end
      udrb_pkg::MODE_RX_FLUSH: begin
        rx_rd = '0; rx_wr = '0; rx_cnt = '0;
      end
      udrb_pkg::MODE_TX_FLUSH: begin
        tx_rd = '0; tx_wr = '0; tx_cnt = '0;
      end
      default: ;
    endcase
    r.tx_irq_on = irq_en;
    r.tx_level  = udrb_pkg::LEVEL_W'(tx_cnt);
    r.rx_level  = udrb_pkg::LEVEL_W'(rx_cnt);
    return r;
  endfunction

  // Offers one request; returns at the edge where it is taken, tvalid left high.
  task automatic send_request(logic [udrb_pkg::MODE_W-1:0] op,
                              logic [udrb_pkg::BYTE_W-1:0] b);
    @(negedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(udrb_pkg::IN_DATA_W - udrb_pkg::BYTE_W - udrb_pkg::MODE_W){1'b0}},
                  b, op};
    do @(posedge clk); while (in_tready !== 1'b1);
    due_results.push_back(apply_ring_op(op, b));
  endtask

  task automatic end_burst();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  // Sender stays quiet until every result is back.
  task automatic wait_all_results();
    int guard;
    guard = 0;
    end_burst();
    while (due_results.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    if (due_results.size() != 0) begin
      report_mismatch("results never returned", due_results.size(), 0);
      due_results.delete();
    end
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic set_idling(int snd, int rcv);
    send_idle_pct = snd;
    recv_idle_pct = rcv;
  endtask

  // Empty-ring refusals, full tx refusal, rx overwrite, flushes, unused modes.
  task automatic test_directed();
    logic [udrb_pkg::BYTE_W-1:0] pattern [9] = '{8'h00, 8'hFF, 8'h5A, 8'hA5, 8'h01,
                                                 8'h80, 8'h7F, 8'hFE, 8'h33};
    send_request(udrb_pkg::MODE_RX_POP, 8'h00);
    send_request(udrb_pkg::MODE_TX_TAKE, 8'h00);
    for (int i = 0; i < 9; i++) send_request(udrb_pkg::MODE_TX_PUSH, pattern[i]);
    send_request(udrb_pkg::MODE_TX_TAKE, 8'hFF);
    send_request(udrb_pkg::MODE_TX_FLUSH, 8'h00);
    // enable survives the flush until the next take
    send_request(udrb_pkg::MODE_TX_TAKE, 8'h00);
    for (int i = 0; i < 9; i++) send_request(udrb_pkg::MODE_RX_BYTE, pattern[8 - i]);
    send_request(udrb_pkg::MODE_RX_POP, 8'h00);
    send_request(udrb_pkg::MODE_RX_FLUSH, 8'hFF);
    send_request(OP_UNUSED_6, 8'hFF);
    send_request(OP_UNUSED_7, 8'h00);
    wait_all_results();
  endtask

  function automatic logic [udrb_pkg::MODE_W-1:0] pick_op(bit fill_bias);
    int r, hi, lo;
    r  = $urandom_range(99);
    hi = fill_bias ? 32 : 12;
    lo = fill_bias ? 12 : 32;
    if (r < hi)                return udrb_pkg::MODE_TX_PUSH;
    if (r < hi + lo)           return udrb_pkg::MODE_TX_TAKE;
    if (r < 2 * hi + lo)       return udrb_pkg::MODE_RX_BYTE;
    if (r < 2 * hi + 2 * lo)   return udrb_pkg::MODE_RX_POP;
    if (r < 91)                return udrb_pkg::MODE_RX_FLUSH;
    if (r < 94)                return udrb_pkg::MODE_TX_FLUSH;
    return (r < 97) ? OP_UNUSED_6 : OP_UNUSED_7;
  endfunction

  function automatic logic [udrb_pkg::BYTE_W-1:0] pick_byte();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return udrb_pkg::BYTE_W'($urandom_range(255));
  endfunction

  // Bursts lean toward filling or toward emptying, so both rings hit full and empty.
  task automatic test_random_traffic(int count);
    int left, burst;
    bit fill_bias;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(4, 24);
      if (burst > left) burst = left;
      fill_bias = 1'($urandom_range(1));
      for (int i = 0; i < burst; i++) send_request(pick_op(fill_bias), pick_byte());
      left -= burst;
    end
    wait_all_results();
  endtask

  // Receiver holds off while the sender keeps offering, so the input stalls.
  task automatic test_output_stall();
    int saved;
    saved = send_idle_pct;
    send_idle_pct = 0;
    stall_asks++;
    for (int i = 0; i < 30; i++) send_request(pick_op(1'($urandom_range(1))), pick_byte());
    send_idle_pct = saved;
    wait_all_results();
  endtask

  always @(negedge clk) begin
    if (stall_asks != stall_taken) begin
      stall_taken <= stall_asks;
      stall_left  <= STALL_CYCLES - 1;
      out_tready  <= 1'b0;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid === 1'b1 && out_tready === 1'b1) begin
      seen = udrb_pkg::result_t'(out_tdata[$bits(udrb_pkg::result_t)-1:0]);
      if (due_results.size() == 0) begin
        report_mismatch("result with no request pending", int'(out_tdata), 0);
      end else begin
        want = due_results.pop_front();
        if (seen.accepted !== want.accepted)
          report_mismatch("accepted", int'(seen.accepted), int'(want.accepted));
        if (seen.out_byte !== want.out_byte)
          report_mismatch("out_byte", int'(seen.out_byte), int'(want.out_byte));
        if (seen.rx_overwrote !== want.rx_overwrote)
          report_mismatch("rx_overwrote", int'(seen.rx_overwrote),
                          int'(want.rx_overwrote));
        if (seen.tx_irq_on !== want.tx_irq_on)
          report_mismatch("tx_irq_on", int'(seen.tx_irq_on), int'(want.tx_irq_on));
        if (seen.tx_level !== want.tx_level)
          report_mismatch("tx_level", int'(seen.tx_level), int'(want.tx_level));
        if (seen.rx_level !== want.rx_level)
          report_mismatch("rx_level", int'(seen.rx_level), int'(want.rx_level));
      end
    end
  end

  initial begin
    #3000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    ring_model_reset();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    set_idling(33, 73);
    test_directed();
    test_random_traffic(300);

    set_idling(73, 33);
    test_random_traffic(300);
    test_output_stall();

    set_idling(0, 0);
    test_random_traffic(200);

    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
